@@ sv/atp_pkg.sv @@
// ----------------------------------------------------------------------------
// atp_pkg - shared types and constants for the arm tip position block
// Fixed-point widths, CORDIC arctangent table, register indexes and the
// sideband record that travels with each reading through the rotator.
// ----------------------------------------------------------------------------
package atp_pkg;

  // defaults for the top-level parameters
  localparam int SEGMENTS_DEF      = 5;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 20;

  // field widths
  localparam int SEG_W   = 3;
  localparam int RAW_W   = 16;
  localparam int LEN_W   = 16;
  localparam int FLAG_W  = 3;
  localparam int OUT_W   = 21;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 64;

  // datapath widths
  localparam int GAIN_W  = 30;
  localparam int PROD_W  = LEN_W + GAIN_W;  // length times gain
  localparam int XW      = 35;              // rotator vector, mm with 16 fraction bits
  localparam int ZW      = 32;              // rotator angle, 2^-32 turn
  localparam int RW      = 26;              // rounded product, mm with 8 fraction bits
  localparam int SUM_W   = 32;              // accumulator, mm with 8 fraction bits

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032875;

  // register indexes of the configuration port
  localparam logic [CFG_IW-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LENGTHS_LO = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LENGTH_HI  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SEG_FLAGS  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OFFSETS_LO = 3'd5;
  localparam logic [CFG_IW-1:0] REG_OFFSET_HI  = 3'd6;

  // per-segment flag bits
  localparam int FLAG_PITCH = 0;
  localparam int FLAG_INV   = 1;
  localparam int FLAG_DOWN  = 2;

  typedef struct packed {
    logic active;  // reading contributes to the sums
    logic flip;    // angle folded by half a turn
    logic neg_c;   // negate the cosine product
    logic last;    // final reading of a pass
  } atp_side_t;

  // round(atan(2^-i) / (2*pi) * 2^32)
  function automatic logic signed [ZW-1:0] atp_atan(input int i);
    logic signed [ZW-1:0] v;
    v = '0;
    case (i)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/atp_cordic.sv @@
// ----------------------------------------------------------------------------
// atp_cordic - pipelined CORDIC rotator
// One micro-rotation per register stage; the whole pipe moves on adv.
// ----------------------------------------------------------------------------
module atp_cordic
  import atp_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [ZW-1:0] in_z,
  input  atp_side_t            in_side,
  output logic                 out_v,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output atp_side_t            out_side
);

  logic                 v_r    [STAGES];
  logic signed [XW-1:0] x_r    [STAGES];
  logic signed [XW-1:0] y_r    [STAGES];
  logic signed [ZW-1:0] z_r    [STAGES];
  atp_side_t            side_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic                 vi;
    logic signed [XW-1:0] xi, yi, xn, yn;
    logic signed [ZW-1:0] zi, zn;
    atp_side_t            si;

    if (g == 0) begin : g_head
      assign vi = in_v;
      assign xi = in_x;
      assign yi = '0;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_body
      assign vi = v_r[g-1];
      assign xi = x_r[g-1];
      assign yi = y_r[g-1];
      assign zi = z_r[g-1];
      assign si = side_r[g-1];
    end

    // rotate towards zero residual angle
    always_comb begin
      if (!zi[ZW-1]) begin
        xn = xi - (yi >>> g);
        yn = yi + (xi >>> g);
        zn = zi - atp_atan(g);
      end else begin
        xn = xi + (yi >>> g);
        yn = yi - (xi >>> g);
        zn = zi + atp_atan(g);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= vi;
      end
      if (adv) begin
        x_r[g]    <= xn;
        y_r[g]    <= yn;
        z_r[g]    <= zn;
        side_r[g] <= si;
      end
    end
  end

  assign out_v    = v_r[STAGES-1];
  assign out_x    = x_r[STAGES-1];
  assign out_y    = y_r[STAGES-1];
  assign out_side = side_r[STAGES-1];

endmodule

@@ sv/arm_tip_position.sv @@
// ----------------------------------------------------------------------------
// arm_tip_position - planar forward kinematics of a segmented arm
// A result passes the input register, stage B, the CORDIC stages, the round,
// accumulate and output registers after the request carrying last_segment is
// accepted. Throughput: one request per cycle while in_stall is low; the
// CORDIC runs one stage per register; only the accumulate loops between requests.
// in_stall rises only when both the output register and the skid entry hold
// results. Reset (synchronous, rst_n low) clears the configuration registers,
// the sums, the pass flag and all valids; it takes effect at the next clock edge.
// ----------------------------------------------------------------------------
module arm_tip_position
  import atp_pkg::*;
#(
  parameter int SEGMENTS      = SEGMENTS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [CFG_DW-1:0]        cfg_data,

  // sensor readings
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SEG_W-1:0]         in_segment_index,
  input  logic signed [RAW_W-1:0]  in_roll_raw,
  input  logic signed [RAW_W-1:0]  in_pitch_raw,
  input  logic                     in_read_ok,
  input  logic                     in_last_segment,

  // tip position
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  out_reach_mm,
  output logic signed [OUT_W-1:0]  out_depth_mm
);

  // keep only the top ANGLE_BITS bits of the binary angle
  localparam logic [RAW_W-1:0] ANGLE_KEEP =
    ~RAW_W'((17'd1 << (RAW_W - ANGLE_BITS)) - 17'd1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] origin_x_r, origin_y_r;
  logic [63:0]        lengths_lo_r, offsets_lo_r;
  logic [15:0]        length_hi_r, offset_hi_r;
  logic [14:0]        seg_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      lengths_lo_r <= '0;
      length_hi_r  <= '0;
      seg_flags_r  <= '0;
      offsets_lo_r <= '0;
      offset_hi_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   origin_x_r   <= cfg_data[15:0];
        REG_ORIGIN_Y:   origin_y_r   <= cfg_data[15:0];
        REG_LENGTHS_LO: lengths_lo_r <= cfg_data;
        REG_LENGTH_HI:  length_hi_r  <= cfg_data[15:0];
        REG_SEG_FLAGS:  seg_flags_r  <= cfg_data[14:0];
        REG_OFFSETS_LO: offsets_lo_r <= cfg_data;
        REG_OFFSET_HI:  offset_hi_r  <= cfg_data[15:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage before the output register moves unless the skid entry is occupied.
  // in_stall is therefore a plain register output.
  // --------------------------------------------------------------------------
  logic skid_v_r;
  logic adv;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic             a_v_r;
  logic [SEG_W-1:0] a_seg_r;
  logic [RAW_W-1:0] a_roll_r, a_pitch_r;
  logic             a_ok_r, a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
    end
    if (adv) begin
      a_seg_r   <= in_segment_index;
      a_roll_r  <= in_roll_raw;
      a_pitch_r <= in_pitch_raw;
      a_ok_r    <= in_read_ok;
      a_last_r  <= in_last_segment;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: pick segment settings, form the angle, fold it into +-90 degrees
  // and scale the length by the CORDIC gain.
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]      len_sel;
  logic [RAW_W-1:0]      off_sel;
  logic [FLAG_W-1:0]     flags_sel;
  logic [RAW_W-1:0]      ang_axis, ang_off, ang_inv, ang_keep;
  logic signed [16:0]    ang_wide, ang_fold;
  logic                  fold;
  logic                  seg_in_range;
  atp_side_t             b_side_nxt;

  always_comb begin
    unique case (a_seg_r)
      3'd0: begin
        len_sel = lengths_lo_r[15:0];
        off_sel = offsets_lo_r[15:0];
        flags_sel = seg_flags_r[2:0];
      end
      3'd1: begin
        len_sel = lengths_lo_r[31:16];
        off_sel = offsets_lo_r[31:16];
        flags_sel = seg_flags_r[5:3];
      end
      3'd2: begin
        len_sel = lengths_lo_r[47:32];
        off_sel = offsets_lo_r[47:32];
        flags_sel = seg_flags_r[8:6];
      end
      3'd3: begin
        len_sel = lengths_lo_r[63:48];
        off_sel = offsets_lo_r[63:48];
        flags_sel = seg_flags_r[11:9];
      end
      3'd4: begin
        len_sel = length_hi_r;
        off_sel = offset_hi_r;
        flags_sel = seg_flags_r[14:12];
      end
      default: begin
        len_sel = '0;
        off_sel = '0;
        flags_sel = '0;
      end
    endcase

    seg_in_range = 32'(a_seg_r) < SEGMENTS;

    ang_axis = flags_sel[FLAG_PITCH] ? a_pitch_r : a_roll_r;
    ang_off  = ang_axis - off_sel;
    ang_inv  = flags_sel[FLAG_INV] ? (RAW_W'(0) - ang_off) : ang_off;
    ang_keep = ang_inv & ANGLE_KEEP;

    // fold angles past a quarter turn by half a turn; both products flip sign
    ang_wide = $signed({ang_keep[RAW_W-1], ang_keep});
    fold     = 1'b0;
    ang_fold = ang_wide;
    if (ang_wide > 17'sd16384) begin
      ang_fold = ang_wide - 17'sd32768;
      fold     = 1'b1;
    end else if (ang_wide < -17'sd16384) begin
      ang_fold = ang_wide + 17'sd32768;
      fold     = 1'b1;
    end

    b_side_nxt.active = a_ok_r && seg_in_range && (len_sel != '0);
    b_side_nxt.flip   = fold;
    b_side_nxt.neg_c  = fold ^ flags_sel[FLAG_DOWN];
    b_side_nxt.last   = a_last_r;
  end

  logic                 b_v_r;
  logic [PROD_W-1:0]    b_prod_r;
  logic signed [ZW-1:0] b_z_r;
  atp_side_t            b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
    if (adv) begin
      b_prod_r <= PROD_W'(len_sel) * PROD_W'(GAIN_Q30);
      b_z_r    <= $signed({ang_fold[15:0], 16'h0000});
      b_side_r <= b_side_nxt;
    end
  end

  // start vector: length * K in mm with 16 fraction bits, rounded
  logic [PROD_W-1:0]    prod_rnd;
  logic signed [XW-1:0] x_start;

  assign prod_rnd = b_prod_r + PROD_W'(8192);
  assign x_start  = $signed({{(XW-32){1'b0}}, prod_rnd[PROD_W-1:14]});

  // --------------------------------------------------------------------------
  // CORDIC rotator
  // --------------------------------------------------------------------------
  logic                 c_v;
  logic signed [XW-1:0] c_x, c_y;
  atp_side_t            c_side;

  atp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (b_v_r),
    .in_x     (x_start),
    .in_z     (b_z_r),
    .in_side  (b_side_r),
    .out_v    (c_v),
    .out_x    (c_x),
    .out_y    (c_y),
    .out_side (c_side)
  );

  // --------------------------------------------------------------------------
  // Round stage: bring products down to 8 fraction bits, apply sign flips
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] x_half, y_half;
  logic signed [RW-1:0] cos_q8, sin_q8;

  assign x_half = c_x + XW'(128);
  assign y_half = c_y + XW'(128);
  assign cos_q8 = x_half[RW+7:8];
  assign sin_q8 = y_half[RW+7:8];

  logic                 r_v_r;
  logic signed [RW-1:0] r_s_r, r_c_r;
  atp_side_t            r_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= c_v;
    end
    if (adv) begin
      r_s_r    <= c_side.flip  ? -sin_q8 : sin_q8;
      r_c_r    <= c_side.neg_c ? -cos_q8 : cos_q8;
      r_side_r <= c_side;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate stage. A pass opens on the first reading after reset or after
  // a last reading: the sums are loaded with the pivot origin first, even
  // when that reading is skipped.
  // --------------------------------------------------------------------------
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [RW-1:0]    b
  );
    logic signed [SUM_W:0] t;
    t = {a[SUM_W-1], a} + {{(SUM_W+1-RW){b[RW-1]}}, b};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return t[SUM_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  logic                    pass_open_r;
  logic signed [SUM_W-1:0] base_x, base_y, sum_x_nxt, sum_y_nxt;
  logic                    acc_take;

  assign acc_take = r_v_r && adv;

  always_comb begin
    base_x = pass_open_r ? sum_x_r : {{(SUM_W-24){origin_x_r[15]}}, origin_x_r, 8'h00};
    base_y = pass_open_r ? sum_y_r : {{(SUM_W-24){origin_y_r[15]}}, origin_y_r, 8'h00};
    sum_x_nxt = r_side_r.active ? sat_add(base_x, r_s_r) : base_x;
    sum_y_nxt = r_side_r.active ? sat_add(base_y, r_c_r) : base_y;
  end

  logic                    res_v_r;
  logic signed [SUM_W-1:0] res_x_r, res_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      pass_open_r <= 1'b0;
      res_v_r     <= 1'b0;
    end else if (adv) begin
      res_v_r <= acc_take && r_side_r.last;
      if (acc_take) begin
        sum_x_r     <= sum_x_nxt;
        sum_y_r     <= sum_y_nxt;
        pass_open_r <= !r_side_r.last;
      end
    end
    if (adv) begin
      res_x_r <= sum_x_nxt;
      res_y_r <= sum_y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round half up to whole mm, saturate, and hand over through
  // an output register backed by one skid entry.
  // --------------------------------------------------------------------------
  function automatic logic signed [OUT_W-1:0] to_mm(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0]   t;
    logic signed [SUM_W-8:0] q;
    t = {s[SUM_W-1], s} + (SUM_W+1)'(128);
    q = t[SUM_W:8];
    if (q[SUM_W-8:OUT_W-1] != {(SUM_W-OUT_W-6){q[OUT_W-1]}}) begin
      return q[SUM_W-8] ? OUT_MIN : OUT_MAX;
    end
    return q[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] new_x, new_y;
  logic                    out_v_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                    enq, deq;

  assign new_x = to_mm(res_x_r);
  assign new_y = to_mm(res_y_r);
  assign enq   = adv && res_v_r;
  assign deq   = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || deq) begin
      // output register free: refill from skid first, else from the pipe
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= enq;
      end
    end else if (enq) begin
      // held result: park the new one
      skid_v_r <= 1'b1;
    end

    if (!out_v_r || deq) begin
      if (skid_v_r) begin
        out_x_r <= skid_x_r;
        out_y_r <= skid_y_r;
      end else if (enq) begin
        out_x_r <= new_x;
        out_y_r <= new_y;
      end
    end else if (enq) begin
      skid_x_r <= new_x;
      skid_y_r <= new_y;
    end
  end

  assign out_valid    = out_v_r;
  assign out_reach_mm = out_x_r;
  assign out_depth_mm = out_y_r;

endmodule

@@ sv/atp_checker.sv @@
// ----------------------------------------------------------------------------
// atp_checker - port-level checks for the arm tip position block
// Watches the handshake ports and the flow-control relation between them.
// ----------------------------------------------------------------------------
module atp_checker
  import atp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] out_reach_mm,
  input logic signed [OUT_W-1:0] out_depth_mm
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reach_mm) && $stable(out_depth_mm))
    else $error("result changed or vanished while stalled");

  // input is held back only while a result occupies the output register
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // backpressure reaches the input only after a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall rose without a stalled result");

  // reset empties the output side
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall not cleared by reset");

endmodule

bind arm_tip_position atp_checker u_atp_checker (.*);

@@ tb/arm_tip_position_tb.sv @@
// ----------------------------------------------------------------------------
// arm_tip_position_tb - self-checking regression for the arm tip position block
// Drives inclinometer readings through the valid/stall request channel, keeps
// its own fixed-point model of the CORDIC kinematics and the pass bookkeeping,
// and checks every tip position against it. The reset state first, then directed
// corners, accumulator saturation, a long output hold-off and randomised passes
// over many register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module arm_tip_position_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atp_pkg::*;

  localparam int     STAGES        = CORDIC_STAGES_DEF;
  // idle time that lets skipped readings leave the pipeline, with slack on top
  localparam int     SETTLE_CYCLES = CORDIC_STAGES_DEF + 12;
  localparam int     MAX_WAIT      = 17;
  // watchdog limit, set far above the length of the slowest legal run
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     HOLD_CYCLES   = 300;
  localparam longint ACC_MAX       = 64'sd2147483647;
  localparam longint ACC_MIN       = -64'sd2147483648;
  localparam longint MM_MAX        = 1048575;
  localparam longint MM_MIN        = -1048576;
  localparam logic [15:0] ANGLE_KEEP = 16'hFFFF << (16 - ANGLE_BITS_DEF);

  typedef enum {ARM_RANDOM, ARM_MAX, ARM_MIN} arm_shape_t;
  typedef enum {PASS_CLEAN, PASS_BROKEN, PASS_NOISE} pass_kind_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] reach;
    logic signed [OUT_W-1:0] depth;
  } tip_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IW-1:0]       cfg_index;
  logic [CFG_DW-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [SEG_W-1:0]        in_segment_index;
  logic signed [RAW_W-1:0] in_roll_raw;
  logic signed [RAW_W-1:0] in_pitch_raw;
  logic                    in_read_ok;
  logic                    in_last_segment;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_reach_mm;
  logic signed [OUT_W-1:0] out_depth_mm;

  // local copy of the register file
  logic [15:0] arm_origin_x   = '0;
  logic [15:0] arm_origin_y   = '0;
  logic [63:0] arm_lengths_lo = '0;
  logic [15:0] arm_length_hi  = '0;
  logic [14:0] arm_seg_flags  = '0;
  logic [63:0] arm_offsets_lo = '0;
  logic [15:0] arm_offset_hi  = '0;

  // tracked kinematic state, mm with 8 fraction bits
  int   reach_acc = 0;
  int   height_acc = 0;
  bit   pass_live = 1'b0;
  tip_t tips_due[$];

  int   errors      = 0;
  int   items_sent  = 0;
  int   cycle_count = 0;
  bit   tx_idle     = 1'b0;
  bit   rx_idle     = 1'b0;
  int   rx_gap      = 0;
  int   rx_hold_req = 0;

  arm_tip_position dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_segment_index (in_segment_index),
    .in_roll_raw      (in_roll_raw),
    .in_pitch_raw     (in_pitch_raw),
    .in_read_ok       (in_read_ok),
    .in_last_segment  (in_last_segment),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reach_mm     (out_reach_mm),
    .out_depth_mm     (out_depth_mm)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Kinematics model
  // --------------------------------------------------------------------------

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic longint turn_of_stage(input int i);
    longint v;
    case (i)
      0:  v = 536870912;
      1:  v = 316933406;
      2:  v = 167458907;
      3:  v = 85004756;
      4:  v = 42667331;
      5:  v = 21354465;
      6:  v = 10679838;
      7:  v = 5340245;
      8:  v = 2670163;
      9:  v = 1335087;
      10: v = 667544;
      11: v = 333772;
      12: v = 166886;
      13: v = 83443;
      14: v = 41722;
      15: v = 20861;
      16: v = 10430;
      17: v = 5215;
      18: v = 2608;
      19: v = 1304;
      default: v = 0;
    endcase
    return v;
  endfunction

  // cos and sin of a binary angle, times the length, in Q8 mm
  function automatic void segment_vector(input logic [15:0] ang, input logic [15:0] len,
                                         output longint cos_q8, output longint sin_q8);
    longint a, x, y, z, nx;
    bit     half_turn;
    a = longint'($signed(ang));
    half_turn = 1'b0;
    // fold anything past a quarter turn back by half a turn
    if (a > 16384) begin
      a = a - 32768;
      half_turn = 1'b1;
    end else if (a < -16384) begin
      a = a + 32768;
      half_turn = 1'b1;
    end
    z = a * 65536;
    x = (longint'(len) * longint'(GAIN_Q30) + 8192) >>> 14;
    y = 0;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - turn_of_stage(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + turn_of_stage(i);
      end
      x = nx;
    end
    x = (x + 128) >>> 8;
    y = (y + 128) >>> 8;
    if (half_turn) begin
      x = -x;
      y = -y;
    end
    cos_q8 = x;
    sin_q8 = y;
  endfunction

  function automatic int clamp_acc(input int acc, input longint delta);
    longint r;
    r = longint'(acc) + delta;
    if (r > ACC_MAX) r = ACC_MAX;
    if (r < ACC_MIN) r = ACC_MIN;
    return int'(r);
  endfunction

  function automatic logic signed [OUT_W-1:0] q8_to_mm(input int acc);
    longint r;
    r = (longint'(acc) + 128) >>> 8;
    if (r > MM_MAX) r = MM_MAX;
    if (r < MM_MIN) r = MM_MIN;
    return r[OUT_W-1:0];
  endfunction

  // apply one accepted reading; queue a tip position when it closes the pass
  function automatic void fold_reading(input logic [SEG_W-1:0] seg, input logic [15:0] roll,
                                       input logic [15:0] pitch, input logic ok,
                                       input logic last);
    logic [15:0] len, off, ang;
    logic [2:0]  flags;
    longint      c, s;
    tip_t        tip;
    // a new pass starts from the pivot origin, skipped or not
    if (!pass_live) begin
      reach_acc  = int'($signed(arm_origin_x)) * 256;
      height_acc = int'($signed(arm_origin_y)) * 256;
      pass_live  = 1'b1;
    end
    if (ok && seg < SEGMENTS_DEF) begin
      if (seg < 4) begin
        len = arm_lengths_lo[16*seg +: 16];
        off = arm_offsets_lo[16*seg +: 16];
      end else begin
        len = arm_length_hi;
        off = arm_offset_hi;
      end
      flags = arm_seg_flags[3*seg +: 3];
      if (len != 0) begin
        ang = flags[FLAG_PITCH] ? pitch : roll;
        ang = ang - off;
        if (flags[FLAG_INV]) ang = 16'd0 - ang;
        ang = ang & ANGLE_KEEP;
        segment_vector(ang, len, c, s);
        reach_acc  = clamp_acc(reach_acc, s);
        height_acc = clamp_acc(height_acc, flags[FLAG_DOWN] ? -c : c);
      end
    end
    if (last) begin
      tip.reach = q8_to_mm(reach_acc);
      tip.depth = q8_to_mm(height_acc);
      tips_due.push_back(tip);
      pass_live = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // cycles to idle before the next request or result; zero when idling is off
  function automatic int draw_wait(input bit enabled);
    if (!enabled) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // raw angle, weighted towards the quarter and half turn corners
  function automatic logic [15:0] pick_angle();
    logic [15:0] v;
    case ($urandom_range(0, 15))
      0:       v = 16'h0000;
      1:       v = 16'h4000;
      2:       v = 16'h4001;
      3:       v = 16'hC000;
      4:       v = 16'hBFFF;
      5:       v = 16'h7FFF;
      6:       v = 16'h8000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = 16'h7FFF;
      3:       v = 16'h8000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // short arms and random lengths, with the odd zero-length or full-length segment
  function automatic logic [15:0] pick_length();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:          v = 16'h0000;
      1:          v = 16'hFFFF;
      2, 3, 4, 5: v = 16'($urandom_range(1, 2000));
      default:    v = 16'($urandom);
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // write one register while the block is idle and track it locally
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ORIGIN_X:   arm_origin_x   = data[15:0];
      REG_ORIGIN_Y:   arm_origin_y   = data[15:0];
      REG_LENGTHS_LO: arm_lengths_lo = data;
      REG_LENGTH_HI:  arm_length_hi  = data[15:0];
      REG_SEG_FLAGS:  arm_seg_flags  = data[14:0];
      REG_OFFSETS_LO: arm_offsets_lo = data;
      REG_OFFSET_HI:  arm_offset_hi  = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one reading, hold it until the block takes it, then track it
  task automatic send_reading(input logic [SEG_W-1:0] seg, input logic [15:0] roll,
                              input logic [15:0] pitch, input logic ok, input logic last);
    int gap;
    gap = draw_wait(tx_idle);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_segment_index <= seg;
    in_roll_raw      <= roll;
    in_pitch_raw     <= pitch;
    in_read_ok       <= ok;
    in_last_segment  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_reading(seg, roll, pitch, ok, last);
    items_sent++;
  endtask

  // drop the request and wait for every tip position still due
  task automatic wait_for_tips();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tips_due.size() != 0) @(posedge clk);
  endtask

  // as above, then let skipped readings clear the pipeline
  task automatic settle_block();
    wait_for_tips();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // load a full register set; random upper data bits must be ignored
  task automatic shape_arm(input arm_shape_t shape);
    logic [63:0] lens, offs;
    logic [15:0] ox, oy, len4, off4;
    logic [14:0] flags;
    logic [47:0] junk;
    junk = '0;
    case (shape)
      ARM_MAX: begin
        ox = 16'h7FFF; oy = 16'h7FFF; lens = '1; len4 = '1; flags = '1; offs = '1; off4 = '1;
      end
      ARM_MIN: begin
        ox = 16'h8000; oy = 16'h8000; lens = '0; len4 = '0; flags = '0; offs = '0; off4 = '0;
      end
      default: begin
        ox = pick_word();
        oy = pick_word();
        for (int k = 0; k < 4; k++) begin
          lens[16*k +: 16] = pick_length();
          offs[16*k +: 16] = pick_word();
        end
        len4  = pick_length();
        off4  = pick_word();
        flags = 15'($urandom);
        junk  = {$urandom, 16'($urandom)};
      end
    endcase
    write_reg(REG_ORIGIN_X, {junk, ox});
    write_reg(REG_ORIGIN_Y, {junk, oy});
    write_reg(REG_LENGTHS_LO, lens);
    write_reg(REG_LENGTH_HI, {junk, len4});
    write_reg(REG_SEG_FLAGS, {junk, junk[0], flags});
    write_reg(REG_OFFSETS_LO, offs);
    write_reg(REG_OFFSET_HI, {junk, off4});
  endtask

  // one pass of readings, always closed by a last reading
  task automatic send_pass(input pass_kind_t kind);
    int               n;
    logic [SEG_W-1:0] seg;
    logic             ok, last;
    n = (kind == PASS_NOISE) ? $urandom_range(1, 8) : $urandom_range(1, SEGMENTS_DEF);
    for (int k = 0; k < n; k++) begin
      last = (k == n - 1);
      case (kind)
        PASS_CLEAN: begin
          seg = SEG_W'(k);
          ok  = ($urandom_range(0, 15) != 0);
        end
        PASS_BROKEN: begin
          // gaps, repeats and out-of-order segments
          seg = SEG_W'($urandom_range(0, SEGMENTS_DEF - 1));
          ok  = ($urandom_range(0, 3) != 0);
        end
        default: begin
          seg = SEG_W'($urandom);
          ok  = 1'($urandom);
          if (!last) last = ($urandom_range(0, 3) == 0);
        end
      endcase
      send_reading(seg, pick_angle(), pick_angle(), ok, last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // registers at reset: every segment has zero length, so the tip sits at 0,0
  task automatic test_reset_state();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_reading(3'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
    send_reading(3'd4, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
    // out-of-range segment on a failed read, alone in its pass
    send_reading(3'd7, 16'h8000, 16'h7FFF, 1'b0, 1'b1);
  endtask

  task automatic test_directed_corners();
    settle_block();
    write_reg(REG_ORIGIN_X, 64'h7FFF);
    write_reg(REG_ORIGIN_Y, 64'h8000);
    write_reg(REG_LENGTHS_LO, '1);
    write_reg(REG_LENGTH_HI, 64'hFFFF);
    // roll upright, both quarter turns, half a turn and the top of the range
    send_reading(3'd0, 16'h0000, 16'h1234, 1'b1, 1'b0);
    send_reading(3'd1, 16'h4000, 16'hFFFF, 1'b1, 1'b0);
    send_reading(3'd2, 16'h8000, 16'h0000, 1'b1, 1'b0);
    send_reading(3'd3, 16'hC000, 16'h7FFF, 1'b1, 1'b0);
    send_reading(3'd4, 16'h7FFF, 16'h8000, 1'b1, 1'b1);
    settle_block();
    write_reg(REG_SEG_FLAGS, 64'h7FFF);
    write_reg(REG_OFFSETS_LO, 64'hFFFF_8000_4000_0001);
    write_reg(REG_OFFSET_HI, 64'hFFFF);
    // pitch axis, inverted and pointing down everywhere; failed read,
    // indices past the last segment and a repeated segment
    send_reading(3'd0, 16'h0000, 16'h7FFF, 1'b1, 1'b0);
    send_reading(3'd1, 16'hFFFF, 16'h8000, 1'b1, 1'b0);
    send_reading(3'd2, 16'h4000, 16'h4000, 1'b0, 1'b0);
    send_reading(3'd5, 16'h4000, 16'h4000, 1'b1, 1'b0);
    send_reading(3'd6, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_reading(3'd7, 16'hC000, 16'hC000, 1'b1, 1'b0);
    send_reading(3'd3, 16'h0000, 16'h4001, 1'b1, 1'b0);
    send_reading(3'd3, 16'h0000, 16'hBFFF, 1'b1, 1'b0);
    send_reading(3'd4, 16'h7FFF, 16'h0000, 1'b1, 1'b1);
    settle_block();
    write_reg(REG_LENGTH_HI, 64'h0);
    write_reg(REG_SEG_FLAGS, 64'h0);
    // zero-length segment with a good read, then one segment read three times
    send_reading(3'd4, 16'h4000, 16'h4000, 1'b1, 1'b1);
    send_reading(3'd1, 16'h4000, 16'h0000, 1'b1, 1'b0);
    send_reading(3'd1, 16'hC000, 16'h0000, 1'b1, 1'b0);
    send_reading(3'd1, 16'h2000, 16'h0000, 1'b1, 1'b1);
  endtask

  // full-length segments at 45 degrees drive both sums into the clamp,
  // first positive, then negative through the half-turn fold
  task automatic test_accumulator_saturation();
    settle_block();
    write_reg(REG_ORIGIN_X, 64'h0);
    write_reg(REG_ORIGIN_Y, 64'h0);
    write_reg(REG_LENGTHS_LO, '1);
    write_reg(REG_LENGTH_HI, 64'hFFFF);
    write_reg(REG_SEG_FLAGS, 64'h0);
    write_reg(REG_OFFSETS_LO, 64'h0);
    write_reg(REG_OFFSET_HI, 64'h0);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    repeat (190) send_reading(SEG_W'($urandom_range(0, 4)), 16'h2000, 16'($urandom),
                              1'b1, 1'b0);
    send_reading(3'd0, 16'h2000, 16'h0000, 1'b1, 1'b1);
    repeat (190) send_reading(SEG_W'($urandom_range(0, 4)), 16'hA000, 16'($urandom),
                              1'b1, 1'b0);
    send_reading(3'd0, 16'hA000, 16'h0000, 1'b1, 1'b1);
  endtask

  // hold the output off for a long stretch while every request closes a pass,
  // so the pipeline fills and the input stalls
  task automatic test_output_backpressure();
    settle_block();
    shape_arm(ARM_RANDOM);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (60) send_reading(SEG_W'($urandom_range(0, 4)), pick_angle(), pick_angle(),
                             1'b1, 1'b1);
    rx_idle = 1'b1;
    wait_for_tips();
  endtask

  task automatic test_random_passes();
    int         phase_end;
    int         pick;
    arm_shape_t shape;
    for (int phase = 0; phase < 12; phase++) begin
      settle_block();
      if (phase == 0) shape = ARM_MAX;
      else if (phase == 1) shape = ARM_MIN;
      else shape = ARM_RANDOM;
      shape_arm(shape);
      pick = $urandom_range(0, 3);
      tx_idle = pick[0];
      rx_idle = pick[1];
      phase_end = items_sent + 36;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) send_pass(PASS_CLEAN);
        else if (pick < 9) send_pass(PASS_BROKEN);
        else send_pass(PASS_NOISE);
        // now and then pause the sender until the block has drained
        if ($urandom_range(0, 19) == 0) wait_for_tips();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // stall the output for the drawn gap, or for a requested long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted tip position with the oldest one due
  always @(posedge clk) begin : check_tip
    tip_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (tips_due.size() == 0) begin
        errors++;
        $display("%0t unexpected tip position: reach %0d depth %0d",
                 $time, out_reach_mm, out_depth_mm);
      end else begin
        due = tips_due.pop_front();
        if (out_reach_mm !== due.reach) begin
          errors++;
          $display("%0t reach_mm mismatch: expected %0d, actual %0d",
                   $time, due.reach, out_reach_mm);
        end
        if (out_depth_mm !== due.depth) begin
          errors++;
          $display("%0t depth_mm mismatch: expected %0d, actual %0d",
                   $time, due.depth, out_depth_mm);
        end
      end
      rx_gap = draw_wait(rx_idle);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t timeout with %0d tip positions still due", $time, tips_due.size());
    $display("arm_tip_position regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_segment_index = '0;
    in_roll_raw      = '0;
    in_pitch_raw     = '0;
    in_read_ok       = 1'b0;
    in_last_segment  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_corners();
    test_accumulator_saturation();
    test_output_backpressure();
    test_random_passes();
    settle_block();

    if (errors == 0) begin
      $display("arm_tip_position regression: pass");
    end else begin
      $display("arm_tip_position regression: fail");
    end
    $finish;
  end

endmodule

@@ arm_tip_position.f @@
sv/atp_pkg.sv
sv/atp_cordic.sv
sv/arm_tip_position.sv
sv/atp_checker.sv
tb/arm_tip_position_tb.sv
